@@ hdl/smi_pkg.sv @@
// Shared types and constants for the smoothstep interpolator.
// Used by smi_ctrl, smi_datapath and smoothstep_interpolator_top; no dependencies.
`default_nettype none

package smi_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned MAX_SAMPLES = 64;

  localparam logic [CFG_W-1:0] SPP_RESET = 7'd10;
  localparam logic [CFG_W-1:0] SPP_MAX   = CFG_W'(MAX_SAMPLES);
  localparam logic [17:0]      W_THREE   = 18'(3 * 65536);

  // Per-step increment of t = j*65536/n, split as quotient and remainder over n.
  // Entry i serves n = i + 1.
  localparam logic [16:0] RECIP_Q [64] = '{
    17'(65536/1),  17'(65536/2),  17'(65536/3),  17'(65536/4),
    17'(65536/5),  17'(65536/6),  17'(65536/7),  17'(65536/8),
    17'(65536/9),  17'(65536/10), 17'(65536/11), 17'(65536/12),
    17'(65536/13), 17'(65536/14), 17'(65536/15), 17'(65536/16),
    17'(65536/17), 17'(65536/18), 17'(65536/19), 17'(65536/20),
    17'(65536/21), 17'(65536/22), 17'(65536/23), 17'(65536/24),
    17'(65536/25), 17'(65536/26), 17'(65536/27), 17'(65536/28),
    17'(65536/29), 17'(65536/30), 17'(65536/31), 17'(65536/32),
    17'(65536/33), 17'(65536/34), 17'(65536/35), 17'(65536/36),
    17'(65536/37), 17'(65536/38), 17'(65536/39), 17'(65536/40),
    17'(65536/41), 17'(65536/42), 17'(65536/43), 17'(65536/44),
    17'(65536/45), 17'(65536/46), 17'(65536/47), 17'(65536/48),
    17'(65536/49), 17'(65536/50), 17'(65536/51), 17'(65536/52),
    17'(65536/53), 17'(65536/54), 17'(65536/55), 17'(65536/56),
    17'(65536/57), 17'(65536/58), 17'(65536/59), 17'(65536/60),
    17'(65536/61), 17'(65536/62), 17'(65536/63), 17'(65536/64)
  };

  localparam logic [5:0] RECIP_R [64] = '{
    6'(65536%1),  6'(65536%2),  6'(65536%3),  6'(65536%4),
    6'(65536%5),  6'(65536%6),  6'(65536%7),  6'(65536%8),
    6'(65536%9),  6'(65536%10), 6'(65536%11), 6'(65536%12),
    6'(65536%13), 6'(65536%14), 6'(65536%15), 6'(65536%16),
    6'(65536%17), 6'(65536%18), 6'(65536%19), 6'(65536%20),
    6'(65536%21), 6'(65536%22), 6'(65536%23), 6'(65536%24),
    6'(65536%25), 6'(65536%26), 6'(65536%27), 6'(65536%28),
    6'(65536%29), 6'(65536%30), 6'(65536%31), 6'(65536%32),
    6'(65536%33), 6'(65536%34), 6'(65536%35), 6'(65536%36),
    6'(65536%37), 6'(65536%38), 6'(65536%39), 6'(65536%40),
    6'(65536%41), 6'(65536%42), 6'(65536%43), 6'(65536%44),
    6'(65536%45), 6'(65536%46), 6'(65536%47), 6'(65536%48),
    6'(65536%49), 6'(65536%50), 6'(65536%51), 6'(65536%52),
    6'(65536%53), 6'(65536%54), 6'(65536%55), 6'(65536%56),
    6'(65536%57), 6'(65536%58), 6'(65536%59), 6'(65536%60),
    6'(65536%61), 6'(65536%62), 6'(65536%63), 6'(65536%64)
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic start;   // latch target, restart the t generator
    logic issue;   // push one sample into the pipeline
    logic last;    // the issued sample closes the run
    logic finish;  // target becomes the previous point
  } ctrl_cmd_t;

  typedef struct packed {
    logic             adv;    // pipeline moves this cycle
    logic             busy;   // samples still ahead of the output register
    logic [CFG_W-1:0] count;  // samples in the current run, 1..MAX_SAMPLES
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/smi_ctrl.sv @@
// Run sequencer for the smoothstep interpolator: accepts a target, issues one
// sample per cycle while the pipeline advances, then drains. Uses smi_pkg.
`default_nettype none

module smi_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  input  wire smi_pkg::dp_status_t st,
  output smi_pkg::ctrl_cmd_t       cmd
);
  import smi_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic             at_last;

  assign at_last = ({1'b0, k} == (st.count - CFG_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          k_next     = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (st.adv) begin
          cmd.issue = 1'b1;
          cmd.last  = at_last;
          if (at_last) begin
            state_next = ST_DRAIN;
          end else begin
            k_next = k + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        // hold the old previous point until the last blend has left the pipe
        if (!st.busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_issue_on_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> st.adv)
    else $error("sample issued while the pipeline is stalled");

  a_start_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !st.busy)
    else $error("new target accepted with samples still in flight");
`endif

endmodule

`default_nettype wire

@@ hdl/smi_datapath.sv @@
// Datapath for the smoothstep interpolator: sample count register, t generator,
// weight multipliers, blend and output register. Uses smi_pkg.
`default_nettype none

module smi_datapath (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [smi_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire  [smi_pkg::DATA_W-1:0]      target,
  input  wire  smi_pkg::ctrl_cmd_t        cmd,
  output smi_pkg::dp_status_t             st,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [smi_pkg::DATA_W-1:0]      m_tdata,
  output logic                            m_tlast
);
  import smi_pkg::*;

  logic [CFG_W-1:0]  spp, eff, n_run;
  logic [DATA_W-1:0] prev, next_pt;
  logic [16:0]       q, q0;
  logic [5:0]        rem, r0;
  logic [6:0]        rem_sum;
  logic [5:0]        tab_idx;
  logic              adv, wrap;

  logic              v1, v2, last1, last2;
  logic [31:0]       tt1;
  logic [17:0]       w1;
  logic [31:0]       s2;
  logic [49:0]       sprod;

  logic signed [16:0] diff;
  logic signed [32:0] s_ext;
  logic signed [49:0] bprod, base, acc;

  assign eff = (spp == '0) ? CFG_W'(1) : ((spp > SPP_MAX) ? SPP_MAX : spp);
  assign adv = !m_tvalid || m_tready;

  assign st.adv   = adv;
  assign st.busy  = v1 | v2;
  assign st.count = n_run;

  assign tab_idx = 6'(n_run - CFG_W'(1));
  assign q0      = RECIP_Q[tab_idx];
  assign r0      = RECIP_R[tab_idx];
  assign rem_sum = {1'b0, rem} + {1'b0, r0};
  assign wrap    = (rem_sum >= n_run);

  assign sprod = 50'(tt1) * 50'(w1);

  assign diff  = $signed({next_pt[DATA_W-1], next_pt}) - $signed({prev[DATA_W-1], prev});
  assign s_ext = $signed({1'b0, s2});
  assign bprod = 50'(diff) * 50'(s_ext);
  assign base  = $signed({{2{prev[DATA_W-1]}}, prev, 32'b0});
  assign acc   = base + bprod;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      spp      <= SPP_RESET;
      prev     <= '0;
      n_run    <= CFG_W'(1);
      q        <= '0;
      rem      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        spp <= cfg_wdata;
      end
      if (cmd.start) begin
        n_run <= eff;
        q     <= '0;
        rem   <= '0;
      end else if (cmd.issue) begin
        // advance t by 65536/n with the remainder carried exactly
        q   <= q + q0 + 17'(wrap);
        rem <= wrap ? 6'(rem_sum - n_run) : rem_sum[5:0];
      end
      if (cmd.finish) begin
        prev <= next_pt;
      end
      if (adv) begin
        v1       <= cmd.issue;
        v2       <= v1;
        m_tvalid <= v2;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      next_pt <= target;
    end
    if (adv) begin
      tt1     <= 32'(q[15:0]) * 32'(q[15:0]);
      w1      <= W_THREE - {1'b0, q[15:0], 1'b0};
      last1   <= cmd.last;
      s2      <= sprod[47:16];
      last2   <= last1;
      m_tdata <= acc[47:32];
      m_tlast <= last2;
    end
  end

`ifndef SYNTHESIS
  a_t_below_one: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !q[16])
    else $error("t reached one inside a run");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (rem < n_run) && (n_run != '0))
    else $error("t generator remainder out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/smoothstep_interpolator_top.sv @@
// Top level of the smoothstep interpolator: joins the run sequencer and the
// datapath. Depends on smi_pkg, smi_ctrl and smi_datapath.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata = target_point
//   m_*       out        m_tvalid / m_tready  m_tdata = sample_value, m_tlast = last_of_run
//   cfg_*     in         cfg_we               cfg_wdata = samples_per_point
//
// For each target point, n being samples_per_point clamped to 1..64, the block accepts
// the point, issues one sample per cycle while the output does not stall, then drains
// the three-stage weight and blend pipeline before the previous point is updated.
// Output stalls freeze the whole pipeline; the output register holds its sample.
// Reset is synchronous; afterward the previous point is zero and the count is ten.
`default_nettype none

module smoothstep_interpolator_top (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [smi_pkg::DATA_W-1:0]   s_tdata,   // [15:0] target_point
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [smi_pkg::DATA_W-1:0]   m_tdata,   // [15:0] sample_value
  output logic                         m_tlast,
  input  wire                          cfg_we,
  input  wire  [smi_pkg::CFG_W-1:0]    cfg_wdata
);
  import smi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  smi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  smi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .target    (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/smi_stream_checker.sv @@
// Stream checker for the smoothstep interpolator: watches the input, output and
// configuration ports, predicts every sample and compares it. Depends on smi_pkg.
`default_nettype none

module smi_stream_checker (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  input  wire                         s_tready,
  input  wire  [smi_pkg::DATA_W-1:0]  s_tdata,     // [15:0] target_point
  input  wire                         m_tvalid,
  input  wire                         m_tready,
  input  wire  [smi_pkg::DATA_W-1:0]  m_tdata,     // [15:0] sample_value
  input  wire                         m_tlast,
  input  wire                         cfg_we,
  input  wire  [smi_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          mismatches,
  output int                          outstanding,
  output int                          samples_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import smi_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } sample_t;

  sample_t                   expected_samples[$];
  logic [CFG_W-1:0]          count_shadow;
  logic signed [DATA_W-1:0]  prev_point;

  // Zero acts as one, anything above the maximum saturates.
  function automatic int unsigned run_length(logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > SPP_MAX) begin
      return MAX_SAMPLES;
    end
    return int'(raw);
  endfunction

  // Smoothstep weight t*t*(3-2t) in Q0.32 for step j of n, t in Q0.16.
  function automatic logic [31:0] smooth_weight(int unsigned j, int unsigned n);
    longint unsigned t;
    longint unsigned s48;
    t   = (longint'(j) * 65536) / longint'(n);
    s48 = t * t * (64'd196608 - 64'd2 * t);
    return s48[47:16];
  endfunction

  // prev*(1-s) + next*s, floored.
  function automatic logic [DATA_W-1:0] blend_sample(logic signed [DATA_W-1:0] from_pt,
                                                     logic signed [DATA_W-1:0] to_pt,
                                                     logic [31:0] w);
    longint diff;
    longint acc;
    diff = longint'(to_pt) - longint'(from_pt);
    acc  = longint'(from_pt) * 64'sh1_0000_0000 + diff * longint'({32'b0, w});
    acc  = acc >>> 32;
    return acc[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    int unsigned n;
    sample_t     want;
    int          fails;
    fails = 0;
    if (rst) begin
      count_shadow <= SPP_RESET;
      prev_point   <= '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        count_shadow <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        n = run_length(count_shadow);
        for (int unsigned j = 0; j < n; j++) begin
          want.value = blend_sample(prev_point, s_tdata, smooth_weight(j, n));
          want.last  = (j + 1 == n);
          expected_samples.push_back(want);
        end
        prev_point <= s_tdata;
      end
      if (m_tvalid && m_tready) begin
        samples_seen <= samples_seen + 1;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample transaction: actual value %h last %b",
                   $time, m_tdata, m_tlast);
          fails++;
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: sample_value mismatch: expected %h actual %h",
                     $time, want.value, m_tdata);
            fails++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b actual %b",
                     $time, want.last, m_tlast);
            fails++;
          end
        end
      end
    end
    if (fails != 0) begin
      mismatches <= mismatches + fails;
    end
    outstanding <= expected_samples.size();
  end

endmodule

`default_nettype wire

@@ tb/smoothstep_interpolator_top_tb.sv @@
// Testbench top for smoothstep_interpolator_top: drives target points, sample
// counts and output back-pressure, and reports the verdict of smi_stream_checker.
`default_nettype none

module smoothstep_interpolator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smi_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tlast;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int samples_seen;

  int sender_idle_pct = 0;
  int ready_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int points_sent = 0;
  int settings_used = 0;
  logic [DATA_W-1:0] last_target = '0;

  always #1 clk = ~clk;

  smoothstep_interpolator_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  smi_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .samples_seen (samples_seen)
  );

  // Output back-pressure; a long hold-off is counted here once requested.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(0, 99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still due", cycle_count, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(input logic [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    last_target = v;
    points_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write only with the block idle: every sample out and the pipeline drained.
  task automatic set_count(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] at_reset[10];
    logic [CFG_W-1:0]  spp;
    logic [DATA_W-1:0] tgt;
    at_reset = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
                 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count first; the first run starts from the zero previous point.
    foreach (at_reset[i]) begin
      send_point(at_reset[i]);
    end
    settings_used++;
    set_count(7'd1);
    send_point(16'h8000);
    send_point(16'h7FFF);
    send_point(16'h1234);
    set_count(7'd64);
    send_point(16'h8000);
    send_point(16'h7FFF);
    // zero count acts as one
    set_count(7'd0);
    send_point(16'h0000);
    send_point(16'h7FFF);
    // counts above the maximum saturate
    set_count(7'd127);
    send_point(16'h8000);
    set_count(7'd65);
    send_point(16'h7FFF);
    set_count(7'd2);
    send_point(16'h8000);
    send_point(16'h7FFF);

    for (int seg = 0; seg < 20; seg++) begin
      case ($urandom_range(0, 9))
        0:       spp = 7'd0;
        1:       spp = $urandom_range(0, 1) ? 7'd64 : 7'd127;
        2:       spp = CFG_W'($urandom_range(0, 127));
        default: spp = CFG_W'($urandom_range(1, 16));
      endcase
      set_count(spp);
      case (seg % 5)
        1:       begin sender_idle_pct = 72; ready_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  ready_stall_pct = 72; end
        3:       begin sender_idle_pct = 10; ready_stall_pct = 10; end
        default: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
      endcase
      // Stall the output for a long stretch while points keep coming.
      if (seg == 4 || seg == 14) begin
        hold_requests++;
      end
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(0, 7))
          0:       tgt = 16'h7FFF;
          1:       tgt = 16'h8000;
          2:       tgt = last_target + DATA_W'($urandom_range(0, 31)) - 16'd16;
          default: tgt = DATA_W'($urandom);
        endcase
        send_point(tgt);
      end
    end

    sender_idle_pct = 0;
    ready_stall_pct = 0;
    wait_drained();

    $display("covered %0d target points and %0d samples over %0d sample-count settings,",
             points_sent, samples_seen, settings_used);
    $display("with random gaps on both ports and two long output hold-offs");
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
